@@ rtl/pseq_pkg.sv @@
// shared types and constants for the power sequencer with cool-off
// no dependencies; imported by every module of the block
package pseq_pkg;

    localparam int CFG_W = 16;
    localparam int EXT_W = 32;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ON     = 3'd1;
    localparam logic [2:0] OP_OFF    = 3'd2;
    localparam logic [2:0] OP_REBOOT = 3'd3;
    localparam logic [2:0] OP_TOGGLE = 3'd4;
    localparam logic [2:0] OP_INIT   = 3'd5;

    localparam logic REG_COOLOFF = 1'b0;
    localparam logic REG_REBOOT  = 1'b1;

    localparam logic [CFG_W-1:0] COOLOFF_RESET = 16'd500;
    localparam logic [CFG_W-1:0] REBOOT_RESET  = 16'd300;

    typedef struct packed {
        logic [CFG_W-1:0] cooloff_ticks;
        logic [CFG_W-1:0] reboot_delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic reboot_pending;
        logic cooling_active;
        logic watchdog_disable;
        logic turned_off_event;
        logic turned_on_event;
        logic power_enable;
    } result_t;

endpackage

@@ rtl/pseq_cfg.sv @@
// configuration registers: cool-off and reboot delay tick counts
// depends on pseq_pkg
module pseq_cfg
    import pseq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    logic [CFG_W-1:0] cooloff_reg;
    logic [CFG_W-1:0] reboot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooloff_reg <= COOLOFF_RESET;
            reboot_reg  <= REBOOT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COOLOFF: cooloff_reg <= cfg_data;
                REG_REBOOT:  reboot_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg.cooloff_ticks      = cooloff_reg;
    assign cfg.reboot_delay_ticks = reboot_reg;

endmodule

@@ rtl/pseq_core.sv @@
// rail state, cool-off and reboot timers with their next-state logic
// depends on pseq_pkg
module pseq_core
    import pseq_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic [2:0] opcode,
    input  logic       sig_ok,
    input  logic       bk_on,
    input  cfg_t       cfg,
    output result_t    res
);

    localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};
    localparam logic [COUNTER_BITS-1:0] CNT_ZERO = '0;

    logic                    rail_reg, rail_next;
    logic                    cool_reg, cool_next;
    logic [COUNTER_BITS-1:0] cl_reg, cl_next;
    logic                    arm_reg, arm_next;
    logic [COUNTER_BITS-1:0] rl_reg, rl_next;
    logic                    ev_on, ev_off, ev_wdt;

    logic [EXT_W-1:0]        cool_ext, reb_ext;
    logic [COUNTER_BITS-1:0] cool_load, reb_load;

    // register values truncated or zero-extended to the counter width
    assign cool_ext  = {{(EXT_W-CFG_W){1'b0}}, cfg.cooloff_ticks};
    assign reb_ext   = {{(EXT_W-CFG_W){1'b0}}, cfg.reboot_delay_ticks};
    assign cool_load = cool_ext[COUNTER_BITS-1:0];
    assign reb_load  = reb_ext[COUNTER_BITS-1:0];

    always_comb
    begin
        rail_next = rail_reg;
        cool_next = cool_reg;
        cl_next   = cl_reg;
        arm_next  = arm_reg;
        rl_next   = rl_reg;
        ev_on     = 1'b0;
        ev_off    = 1'b0;
        ev_wdt    = 1'b0;
        case (opcode)
            OP_TICK:
            begin
                if (cool_reg)
                begin
                    if (cl_reg <= CNT_ONE)
                    begin
                        cl_next   = CNT_ZERO;
                        cool_next = 1'b0;
                    end
                    else
                        cl_next = cl_reg - CNT_ONE;
                end
                if (arm_reg)
                begin
                    if (rl_reg <= CNT_ONE)
                    begin
                        rl_next   = CNT_ZERO;
                        arm_next  = 1'b0;
                        rail_next = 1'b1;
                        ev_on     = !rail_reg;
                    end
                    else
                        rl_next = rl_reg - CNT_ONE;
                end
            end
            OP_ON:
            begin
                if (!cool_reg && !rail_reg)
                begin
                    rail_next = 1'b1;
                    ev_on     = 1'b1;
                end
            end
            OP_OFF, OP_REBOOT:
            begin
                rail_next = 1'b0;
                ev_off    = rail_reg;
                cool_next = 1'b1;
                cl_next   = cool_load;
                ev_wdt    = 1'b1;
                if (opcode == OP_REBOOT)
                begin
                    arm_next = 1'b1;
                    rl_next  = reb_load;
                end
            end
            OP_TOGGLE:
            begin
                if (rail_reg)
                begin
                    rail_next = 1'b0;
                    ev_off    = 1'b1;
                    cool_next = 1'b1;
                    cl_next   = cool_load;
                    ev_wdt    = 1'b1;
                end
                else if (!cool_reg)
                begin
                    rail_next = 1'b1;
                    ev_on     = 1'b1;
                end
            end
            OP_INIT:
            begin
                // retained bit taken silently; only a bad signature forcing on gives an event
                if (!sig_ok || bk_on)
                begin
                    rail_next = 1'b1;
                    ev_on     = !sig_ok && !bk_on;
                    cool_next = 1'b0;
                    cl_next   = CNT_ZERO;
                end
                else
                begin
                    rail_next = 1'b0;
                    cool_next = 1'b1;
                    cl_next   = cool_load;
                    ev_wdt    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_reg <= 1'b0;
            cool_reg <= 1'b0;
            cl_reg   <= CNT_ZERO;
            arm_reg  <= 1'b0;
            rl_reg   <= CNT_ZERO;
        end
        else if (adv)
        begin
            rail_reg <= rail_next;
            cool_reg <= cool_next;
            cl_reg   <= cl_next;
            arm_reg  <= arm_next;
            rl_reg   <= rl_next;
        end
    end

    assign res.power_enable     = rail_next;
    assign res.turned_on_event  = ev_on;
    assign res.turned_off_event = ev_off;
    assign res.watchdog_disable = ev_wdt;
    assign res.cooling_active   = cool_next;
    assign res.reboot_pending   = arm_next;

endmodule

@@ rtl/power_sequencer_with_cooloff.sv @@
// top level of the board power-rail sequencer with cool-off and delayed reboot
// depends on pseq_pkg, pseq_cfg and pseq_core
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: opcode, backup_signature_ok, backup_on
//  m_*     | out | m_tvalid/m_tready  | m_tdata: power_enable .. reboot_pending
//  cfg_*   | in  | cfg_we (no wait)   | cfg_index, cfg_data
//
// one request per cycle sustained while m_tready stays high: each request is
// held in the input register, then the state update and result go through one
// level of logic into the result register, which drives m_tvalid; while that
// register holds an untaken result, the request waits in the input register
// reset clears the valid flags, the rail state and both timers; registers
// return to 500 and 300 ticks
// a stalled result holds m_tdata; s_tready stays high while the input register
// is empty or its request moves on into a free or draining result register
module power_sequencer_with_cooloff
    import pseq_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [2:0] opcode, [3] backup_signature_ok, [4] backup_on
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] power_enable, [1] turned_on_event,
                                        // [2] turned_off_event, [3] watchdog_disable,
                                        // [4] cooling_active, [5] reboot_pending
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t res;

    // input register
    logic       in_vld_reg;
    logic [2:0] op_reg;
    logic       sig_reg;
    logic       bk_reg;

    // result register
    logic       out_vld_reg;
    result_t    out_reg;

    logic       adv;

    // request moves into the result register when that is free or drained
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (adv)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg  <= s_tdata[2:0];
            sig_reg <= s_tdata[3];
            bk_reg  <= s_tdata[4];
        end
        if (adv)
            out_reg <= res;
    end

    pseq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pseq_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .opcode (op_reg),
        .sig_ok (sig_reg),
        .bk_on  (bk_reg),
        .cfg    (cfg),
        .res    (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule

@@ tb/power_sequencer_with_cooloff_tb.sv @@
// self-checking testbench for the power sequencer with cool-off and delayed reboot
// depends on pseq_pkg and the power_sequencer_with_cooloff top level; drives requests
// from a queue, predicts every result in-bench and checks it field by field
module power_sequencer_with_cooloff_tb;
    import pseq_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_ITEMS     = 215;
    localparam int NUM_SEGS      = 8;
    localparam logic [CFG_W-1:0] TIMER_MAX = '1;

    // sequencer state as the predictor tracks it
    typedef struct packed {
        logic             on;
        logic             cooling;
        logic [CFG_W-1:0] cool_left;
        logic             armed;
        logic [CFG_W-1:0] reboot_left;
    } rail_state_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;   // [2:0] opcode, [3] backup_signature_ok, [4] backup_on
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;          // [0] power_enable, [1] turned_on_event,
                                        // [2] turned_off_event, [3] watchdog_disable,
                                        // [4] cooling_active, [5] reboot_pending
    logic             cfg_we    = 1'b0;
    logic             cfg_index = REG_COOLOFF;
    logic [CFG_W-1:0] cfg_data  = '0;

    // predictor copy of the registers and the rail state
    logic [CFG_W-1:0] cooloff_setting = COOLOFF_RESET;
    logic [CFG_W-1:0] reboot_setting  = REBOOT_RESET;
    rail_state_t      rail = '0;

    logic [7:0] pending_requests[$];
    result_t    expected_results[$];
    int         issued     = 0;
    int         accepted   = 0;
    int         mismatches = 0;
    int         cycles     = 0;
    int         idle_pct   = 0;
    int         stall_pct  = 0;

    power_sequencer_with_cooloff #(
        .COUNTER_BITS (16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // next rail state and result for one request; updates the predictor state
    function automatic result_t rail_advance(input logic [7:0] req);
        logic [2:0] op;
        logic       sig_ok;
        logic       bk_on;
        logic       go_on;
        logic       go_off;
        result_t    res;
        op     = req[2:0];
        sig_ok = req[3];
        bk_on  = req[4];
        go_on  = 1'b0;
        go_off = 1'b0;
        res    = '0;
        case (op)
            OP_TICK:
            begin
                if (rail.cooling)
                begin
                    if (rail.cool_left <= 1)
                    begin
                        rail.cool_left = '0;
                        rail.cooling   = 1'b0;
                    end
                    else
                        rail.cool_left = rail.cool_left - 1'b1;
                end
                if (rail.armed)
                begin
                    if (rail.reboot_left <= 1)
                    begin
                        rail.reboot_left = '0;
                        rail.armed       = 1'b0;
                        // forced on, cooling or not
                        if (!rail.on)
                            res.turned_on_event = 1'b1;
                        rail.on = 1'b1;
                    end
                    else
                        rail.reboot_left = rail.reboot_left - 1'b1;
                end
            end
            OP_ON:
                go_on = 1'b1;
            OP_OFF:
                go_off = 1'b1;
            OP_REBOOT:
            begin
                go_off           = 1'b1;
                rail.armed       = 1'b1;
                rail.reboot_left = reboot_setting;
            end
            OP_TOGGLE:
            begin
                if (rail.on)
                    go_off = 1'b1;
                else
                    go_on = 1'b1;
            end
            OP_INIT:
            begin
                // cooling cleared first, so a forced on always takes effect
                rail.cooling   = 1'b0;
                rail.cool_left = '0;
                rail.on        = bk_on;
                if (!sig_ok || bk_on)
                    go_on = 1'b1;
                else
                    go_off = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (go_off)
        begin
            if (rail.on)
                res.turned_off_event = 1'b1;
            rail.on                = 1'b0;
            rail.cooling           = 1'b1;
            rail.cool_left         = cooloff_setting;
            res.watchdog_disable   = 1'b1;
        end
        if (go_on && !rail.cooling && !rail.on)
        begin
            rail.on             = 1'b1;
            res.turned_on_event = 1'b1;
        end
        res.power_enable   = rail.on;
        res.cooling_active = rail.cooling;
        res.reboot_pending = rail.armed;
        return res;
    endfunction

    function automatic logic [7:0] pack_request(input logic [2:0] op, input logic sig_ok,
                                                input logic bk_on);
        return {3'b000, bk_on, sig_ok, op};
    endfunction

    // mostly ticks so that short timers run out; the odd unused opcode
    function automatic logic [7:0] random_request();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(99);
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 67)
            op = OP_ON;
        else if (pick < 75)
            op = OP_OFF;
        else if (pick < 82)
            op = OP_REBOOT;
        else if (pick < 90)
            op = OP_TOGGLE;
        else if (pick < 97)
            op = OP_INIT;
        else
            op = 3'($urandom_range(7, 6));
        return pack_request(op, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // both registers, back to back, write enable held across the pair
    task automatic set_timers(input logic [CFG_W-1:0] cooloff, input logic [CFG_W-1:0] reboot);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COOLOFF;
        cfg_data  <= cooloff;
        cooloff_setting = cooloff;
        @(negedge clk);
        cfg_index <= REG_REBOOT;
        cfg_data  <= reboot;
        reboot_setting = reboot;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all requests taken and every result back; checked at the rising edge,
    // where the queue and s_tvalid are stable
    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0));
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // request driver and receiver back-pressure, both on the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || accepted == issued)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                s_tdata  <= pending_requests.pop_front();
                s_tvalid <= 1'b1;
                issued   <= issued + 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor: predict on request accept, compare on result accept
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(rail_advance(s_tdata));
            accepted <= accepted + 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: m_tdata %02h with nothing outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                got  = result_t'(m_tdata[5:0]);
                check_field("power_enable", want.power_enable, got.power_enable);
                check_field("turned_on_event", want.turned_on_event, got.turned_on_event);
                check_field("turned_off_event", want.turned_off_event, got.turned_off_event);
                check_field("watchdog_disable", want.watchdog_disable, got.watchdog_disable);
                check_field("cooling_active", want.cooling_active, got.cooling_active);
                check_field("reboot_pending", want.reboot_pending, got.reboot_pending);
                check_field("pad_bit6", 1'b0, m_tdata[6]);
                check_field("pad_bit7", 1'b0, m_tdata[7]);
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int seg;
        int k;
        int idle_tbl[4];
        int stall_tbl[4];
        idle_tbl  = '{0, 83, 0, 23};
        stall_tbl = '{0, 0, 83, 23};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // short timers so the directed requests see both expiries
        set_timers(16'd3, 16'd2);

        pending_requests.push_back(pack_request(OP_TICK, 1'b0, 1'b0));    // tick from reset
        pending_requests.push_back(pack_request(OP_ON, 1'b1, 1'b1));      // rail on
        pending_requests.push_back(pack_request(OP_ON, 1'b0, 1'b0));      // on while on
        pending_requests.push_back(pack_request(OP_OFF, 1'b0, 1'b0));     // off, cool-off starts
        pending_requests.push_back(pack_request(OP_ON, 1'b0, 1'b0));      // ignored while cooling
        pending_requests.push_back(pack_request(OP_OFF, 1'b1, 1'b1));     // off while off
        repeat (3) pending_requests.push_back(pack_request(OP_TICK, 1'b0, 1'b0));
        pending_requests.push_back(pack_request(OP_ON, 1'b0, 1'b0));      // accepted again
        pending_requests.push_back(pack_request(OP_REBOOT, 1'b0, 1'b0));
        pending_requests.push_back(pack_request(OP_TICK, 1'b0, 1'b0));
        pending_requests.push_back(pack_request(OP_REBOOT, 1'b0, 1'b0));  // restarts reboot timer
        pending_requests.push_back(pack_request(OP_OFF, 1'b0, 1'b0));     // reboot stays armed
        repeat (2) pending_requests.push_back(pack_request(OP_TICK, 1'b0, 1'b0)); // forced on
        pending_requests.push_back(pack_request(OP_TOGGLE, 1'b0, 1'b0));  // on to off
        pending_requests.push_back(pack_request(OP_TOGGLE, 1'b1, 1'b1));  // off, still cooling
        pending_requests.push_back(pack_request(OP_REBOOT, 1'b0, 1'b0));
        pending_requests.push_back(pack_request(OP_INIT, 1'b0, 1'b0));    // bad signature, off bit
        pending_requests.push_back(pack_request(OP_INIT, 1'b1, 1'b1));    // good signature, on bit
        pending_requests.push_back(pack_request(OP_INIT, 1'b1, 1'b0));    // good signature, off bit
        pending_requests.push_back(pack_request(OP_INIT, 1'b0, 1'b1));    // bad signature, on bit
        pending_requests.push_back(pack_request(3'd6, 1'b1, 1'b1));       // unused opcodes
        pending_requests.push_back(pack_request(3'd7, 1'b0, 1'b1));
        wait_drained();

        // largest timers: counts start at the top and step down without wrapping
        set_timers(TIMER_MAX, TIMER_MAX);
        pending_requests.push_back(pack_request(OP_REBOOT, 1'b0, 1'b0));
        repeat (4) pending_requests.push_back(pack_request(OP_TICK, 1'b0, 1'b0));
        pending_requests.push_back(pack_request(OP_ON, 1'b0, 1'b0));      // still cooling
        pending_requests.push_back(pack_request(OP_OFF, 1'b0, 1'b0));
        wait_drained();

        // random segments across the idle/stall mixes and several timer settings
        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg)
                0:       set_timers(16'd1, 16'd1);
                3:       set_timers(TIMER_MAX, 16'd2);
                5:       set_timers(16'd7, TIMER_MAX);
                default: set_timers(16'($urandom_range(24, 1)), 16'($urandom_range(24, 1)));
            endcase
            idle_pct  = idle_tbl[seg % 4];
            stall_pct = stall_tbl[seg % 4];
            for (k = 0; k < SEG_ITEMS; k++)
                pending_requests.push_back(random_request());
            wait_drained();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pseq_pkg.sv
rtl/pseq_cfg.sv
rtl/pseq_core.sv
rtl/power_sequencer_with_cooloff.sv
tb/power_sequencer_with_cooloff_tb.sv
